// ----- hw/rtl/rrrt_pkg.sv -----
// Shared types and constants for the register rename and reorder table.
// No dependencies.
package rrrt_pkg;
   localparam logic [1:0] OP_ISSUE = 2'd0;
   localparam logic [1:0] OP_WB = 2'd1;
   localparam logic [1:0] OP_COMMIT = 2'd2;
   localparam logic [1:0] OP_NOP = 2'd3;
   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_PENDING = 2'd3;

   typedef struct packed {
      logic [1:0] opcode;
      logic src1_used;
      logic src1_is_fp;
      logic [5:0] src1_index;
      logic src2_used;
      logic src2_is_fp;
      logic [5:0] src2_index;
      logic dst_used;
      logic dst_is_fp;
      logic [5:0] dst_index;
      logic [3:0] wb_tag;
      logic [31:0] wb_value;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic src1_ready;
      logic [3:0] src1_tag;
      logic [31:0] src1_value;
      logic src2_ready;
      logic [3:0] src2_tag;
      logic [31:0] src2_value;
      logic [3:0] dst_tag;
      logic [3:0] retired_tag;
      logic [4:0] occupancy;
   } rsp_type;
endpackage

// ----- hw/rtl/rrrt_req_if.sv -----
// Request channel interface.
// Depends on rrrt_pkg.
interface rrrt_req_if;
   logic valid;
   logic ready;
   rrrt_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/rrrt_rsp_if.sv -----
// Response channel interface.
// Depends on rrrt_pkg.
interface rrrt_rsp_if;
   logic valid;
   logic ready;
   rrrt_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/rrrt_alias_file.sv -----
// Alias table for one register file: rename bits, tags, speculative and
// architectural values, with parallel writeback match. No dependencies.
module rrrt_alias_file #(
   parameter int REGS = 36,
   parameter int TW = 4
) (
   input logic clock,
   input logic reset,
   input logic [5:0] rd1_index,
   output logic rd1_renamed,
   output logic [TW-1:0] rd1_tag,
   output logic [31:0] rd1_value,
   input logic [5:0] rd2_index,
   output logic rd2_renamed,
   output logic [TW-1:0] rd2_tag,
   output logic [31:0] rd2_value,
   input logic ren_en,
   input logic [5:0] ren_index,
   input logic [TW-1:0] ren_tag,
   input logic wb_en,
   input logic [TW-1:0] wb_tag,
   input logic [31:0] wb_value,
   input logic commit_en
);
   logic [REGS-1:0] renamed_ff, renamed_in;
   logic [TW-1:0] tag_ff [REGS];
   logic [31:0] spec_ff [REGS];
   logic [31:0] arch_ff [REGS];

   always_comb begin
      rd1_renamed = 1'b0; rd1_tag = '0; rd1_value = '0;
      rd2_renamed = 1'b0; rd2_tag = '0; rd2_value = '0;
      for (int i = 0; i < REGS; i++) begin
         if (rd1_index == 6'(i)) begin
            rd1_renamed = renamed_ff[i]; rd1_tag = tag_ff[i]; rd1_value = spec_ff[i];
         end
         if (rd2_index == 6'(i)) begin
            rd2_renamed = renamed_ff[i]; rd2_tag = tag_ff[i]; rd2_value = spec_ff[i];
         end
      end
   end

   always_comb begin
      renamed_in = renamed_ff;
      for (int i = 0; i < REGS; i++) begin
         if (wb_en && renamed_ff[i] && tag_ff[i] == wb_tag) renamed_in[i] = 1'b0;
         if (ren_en && ren_index == 6'(i)) renamed_in[i] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         renamed_ff <= '0;
         for (int i = 0; i < REGS; i++) begin
            tag_ff[i] <= '0; spec_ff[i] <= '0; arch_ff[i] <= '0;
         end
      end else begin
         renamed_ff <= renamed_in;
         for (int i = 0; i < REGS; i++) begin
            if (wb_en && renamed_ff[i] && tag_ff[i] == wb_tag) spec_ff[i] <= wb_value;
            if (ren_en && ren_index == 6'(i)) tag_ff[i] <= ren_tag;
            if (commit_en) arch_ff[i] <= spec_ff[i];
         end
      end
   end
endmodule

// ----- hw/rtl/rrrt_rob_ctrl.sv -----
// Reorder buffer control: head, tail, count, done bits and entry records.
// Depends on rrrt_pkg.
module rrrt_rob_ctrl #(
   parameter int DEPTH = 16,
   parameter int TW = 4
) (
   input logic clock,
   input logic reset,
   input logic [4:0] csr_wdata,
   input logic csr_we,
   input logic [1:0] opcode,
   input logic fire,
   input logic [6:0] dest,
   input logic [3:0] wb_tag,
   input logic [31:0] wb_value,
   output logic issue_ok,
   output logic commit_ok,
   output logic wb_ok,
   output logic [1:0] status,
   output logic [TW-1:0] tail,
   output logic [TW-1:0] head,
   output logic [4:0] count_next
);
   localparam int CW = $clog2(DEPTH + 1);
   logic [4:0] limit_ff;
   logic [TW-1:0] head_ff, tail_ff;
   logic [CW-1:0] count_ff;
   logic [DEPTH-1:0] done_ff;
   logic [31:0] value_ff [DEPTH];
   logic [6:0] dest_ff [DEPTH];
   logic [CW-1:0] wrap;
   logic [TW-1:0] tail_in, head_in;

   always_comb begin
      if (limit_ff == 5'd0) wrap = CW'(1);
      else if (32'(limit_ff) > DEPTH) wrap = CW'(DEPTH);
      else wrap = CW'(limit_ff);
      issue_ok = fire && opcode == rrrt_pkg::OP_ISSUE && count_ff < wrap;
      wb_ok = fire && opcode == rrrt_pkg::OP_WB && 32'(wb_tag) < DEPTH;
      commit_ok = fire && opcode == rrrt_pkg::OP_COMMIT && count_ff != '0 && done_ff[head_ff];
      status = rrrt_pkg::ST_DONE;
      if (opcode == rrrt_pkg::OP_ISSUE && count_ff >= wrap) status = rrrt_pkg::ST_FULL;
      else if (opcode == rrrt_pkg::OP_COMMIT && count_ff == '0) status = rrrt_pkg::ST_EMPTY;
      else if (opcode == rrrt_pkg::OP_COMMIT && !done_ff[head_ff])
         status = rrrt_pkg::ST_PENDING;
      tail_in = ({1'b0, tail_ff} + 1'b1 >= (TW+1)'(wrap)) ? '0 : tail_ff + 1'b1;
      head_in = ({1'b0, head_ff} + 1'b1 >= (TW+1)'(wrap)) ? '0 : head_ff + 1'b1;
      count_next = 5'(count_ff);
      if (issue_ok) count_next = 5'(count_ff + 1'b1);
      else if (commit_ok) count_next = 5'(count_ff - 1'b1);
      tail = tail_ff;
      head = head_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 5'd16;
         head_ff <= '0; tail_ff <= '0; count_ff <= '0; done_ff <= '0;
      end else begin
         if (csr_we) limit_ff <= csr_wdata;
         count_ff <= CW'(count_next);
         if (issue_ok) begin
            tail_ff <= tail_in;
            done_ff[tail_ff] <= 1'b0;
         end
         if (wb_ok) done_ff[TW'(wb_tag)] <= 1'b1;
         if (commit_ok) begin
            head_ff <= head_in;
            done_ff[head_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue_ok) dest_ff[tail_ff] <= dest;
      if (wb_ok) value_ff[TW'(wb_tag)] <= wb_value;
   end

   logic unused;
   assign unused = ^{value_ff[head_ff], dest_ff[head_ff]};
endmodule

// ----- hw/rtl/register_rename_reorder_table.sv -----
// Register rename table with reorder buffer, top level.
// The response is registered and is valid in the cycle after the request is accepted.
// Throughput: one item per cycle while the response is taken (rsp.ready high); the response register frees on take.
// Reset: synchronous; aliases, values, pointers cleared, wrap point 16.
// Depends on rrrt_pkg, rrrt_req_if, rrrt_rsp_if, rrrt_alias_file, rrrt_rob_ctrl.
module register_rename_reorder_table #(
   parameter int INT_REGS = 36,
   parameter int FP_REGS = 36,
   parameter int ROB_DEPTH = 16
) (
   input logic clock,
   input logic reset,
   rrrt_req_if.sink req,
   rrrt_rsp_if.source rsp,
   input logic csr_we,
   input logic [4:0] csr_wdata
);
   localparam int TW = $clog2(ROB_DEPTH);
   rrrt_pkg::req_type r;
   rrrt_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, fire;
   logic issue_ok, commit_ok, wb_ok;
   logic [1:0] status;
   logic [TW-1:0] tail, head;
   logic [4:0] count_next;
   logic i1r, i2r, f1r, f2r;
   logic [TW-1:0] i1t, i2t, f1t, f2t;
   logic [31:0] i1v, i2v, f1v, f2v;
   logic ren_int, ren_fp;

   assign r = req.data;
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign fire = req.valid && req.ready;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_ff;

   assign ren_int = issue_ok && r.dst_used && !r.dst_is_fp && 32'(r.dst_index) < INT_REGS;
   assign ren_fp = issue_ok && r.dst_used && r.dst_is_fp && 32'(r.dst_index) < FP_REGS;

   rrrt_alias_file #(.REGS(INT_REGS), .TW(TW)) u_int (
      .clock, .reset,
      .rd1_index(r.src1_index), .rd1_renamed(i1r), .rd1_tag(i1t), .rd1_value(i1v),
      .rd2_index(r.src2_index), .rd2_renamed(i2r), .rd2_tag(i2t), .rd2_value(i2v),
      .ren_en(ren_int), .ren_index(r.dst_index), .ren_tag(tail),
      .wb_en(wb_ok), .wb_tag(TW'(r.wb_tag)), .wb_value(r.wb_value),
      .commit_en(commit_ok));

   rrrt_alias_file #(.REGS(FP_REGS), .TW(TW)) u_fp (
      .clock, .reset,
      .rd1_index(r.src1_index), .rd1_renamed(f1r), .rd1_tag(f1t), .rd1_value(f1v),
      .rd2_index(r.src2_index), .rd2_renamed(f2r), .rd2_tag(f2t), .rd2_value(f2v),
      .ren_en(ren_fp), .ren_index(r.dst_index), .ren_tag(tail),
      .wb_en(wb_ok), .wb_tag(TW'(r.wb_tag)), .wb_value(r.wb_value),
      .commit_en(commit_ok));

   rrrt_rob_ctrl #(.DEPTH(ROB_DEPTH), .TW(TW)) u_rob (
      .clock, .reset, .csr_wdata, .csr_we,
      .opcode(r.opcode), .fire,
      .dest({r.dst_is_fp, r.dst_used ? r.dst_index : 6'h3f}),
      .wb_tag(r.wb_tag), .wb_value(r.wb_value),
      .issue_ok, .commit_ok, .wb_ok, .status, .tail, .head, .count_next);

   always_comb begin
      rsp_in = '0;
      rsp_in.status = status;
      rsp_in.occupancy = count_next;
      if (issue_ok) begin
         rsp_in.src1_ready = 1'b1;
         rsp_in.src2_ready = 1'b1;
         if (r.src1_used) begin
            if (r.src1_is_fp && 32'(r.src1_index) < FP_REGS) begin
               rsp_in.src1_ready = !f1r;
               rsp_in.src1_tag = f1r ? 4'(f1t) : 4'd0;
               rsp_in.src1_value = f1r ? 32'd0 : f1v;
            end else if (!r.src1_is_fp && 32'(r.src1_index) < INT_REGS) begin
               rsp_in.src1_ready = !i1r;
               rsp_in.src1_tag = i1r ? 4'(i1t) : 4'd0;
               rsp_in.src1_value = i1r ? 32'd0 : i1v;
            end
         end
         if (r.src2_used) begin
            if (r.src2_is_fp && 32'(r.src2_index) < FP_REGS) begin
               rsp_in.src2_ready = !f2r;
               rsp_in.src2_tag = f2r ? 4'(f2t) : 4'd0;
               rsp_in.src2_value = f2r ? 32'd0 : f2v;
            end else if (!r.src2_is_fp && 32'(r.src2_index) < INT_REGS) begin
               rsp_in.src2_ready = !i2r;
               rsp_in.src2_tag = i2r ? 4'(i2t) : 4'd0;
               rsp_in.src2_value = i2r ? 32'd0 : i2v;
            end
         end
         rsp_in.dst_tag = 4'(tail);
      end
      if (commit_ok) rsp_in.retired_tag = 4'(head);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) rsp_ff <= rsp_in;
   end
endmodule
